// ===== design/sdtf_pkg.sv =====
// shared types and constants for the signed decimal text formatter
// no dependencies
`default_nettype none

package sdtf_pkg;

   localparam int MAX_CHARS  = 64;
   localparam int NUM_DIGITS = 10;
   localparam int CONV_STEPS = 32;
   localparam int VALUE_W    = 32;
   localparam int COUNT_W    = 7;
   localparam int DIGIT_W    = 4;
   localparam int STEP_W     = 5;
   localparam int NDIG_W     = 4;
   localparam int PREC_W     = 6;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_COUNT,
      ST_LAYOUT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic count;
      logic layout;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic conv_done;
      logic empty;
      logic out_free;
      logic last_pos;
   } ctrl_sts_type;

endpackage

`default_nettype wire

// ===== design/sdtf_if.sv =====
// request and response channel interfaces for the formatter
// depends on sdtf_pkg
`default_nettype none

interface sdtf_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [sdtf_pkg::VALUE_W-1:0]  value;
   logic                                 force_plus;
   logic                                 space_sign;
   logic                                 left_justify;
   logic                                 zero_pad;
   logic                                 has_precision;
   logic        [sdtf_pkg::PREC_W-1:0]   precision;
   logic        [sdtf_pkg::COUNT_W-1:0]  field_width;

   modport source (output valid, value, force_plus, space_sign, left_justify, zero_pad,
                   has_precision, precision, field_width, input ready);
   modport sink   (input valid, value, force_plus, space_sign, left_justify, zero_pad,
                   has_precision, precision, field_width, output ready);
endinterface

interface sdtf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [7:0]                          char_out;
   logic                                last_char;
   logic [sdtf_pkg::COUNT_W-1:0]        total_chars;

   modport source (output valid, char_out, last_char, total_chars, input ready);
   modport sink   (input valid, char_out, last_char, total_chars, output ready);
endinterface

`default_nettype wire

// ===== design/sdtf_ctrl.sv =====
// controller state machine: sequences conversion, layout and character beats
// depends on sdtf_pkg
`default_nettype none

module sdtf_ctrl (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire sdtf_pkg::ctrl_sts_type sts,
   output sdtf_pkg::ctrl_cmd_type      cmd
);

   sdtf_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdtf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sdtf_pkg::ST_IDLE: begin
            if (req_valid) state_in = sdtf_pkg::ST_CONVERT;
         end
         sdtf_pkg::ST_CONVERT: begin
            if (sts.conv_done) state_in = sdtf_pkg::ST_COUNT;
         end
         sdtf_pkg::ST_COUNT: begin
            state_in = sdtf_pkg::ST_LAYOUT;
         end
         sdtf_pkg::ST_LAYOUT: begin
            state_in = sts.empty ? sdtf_pkg::ST_IDLE : sdtf_pkg::ST_EMIT;
         end
         sdtf_pkg::ST_EMIT: begin
            if (sts.out_free && sts.last_pos) state_in = sdtf_pkg::ST_IDLE;
         end
         default: begin
            state_in = sdtf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         sdtf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         sdtf_pkg::ST_CONVERT: begin
            cmd.shift = 1'b1;
         end
         sdtf_pkg::ST_COUNT: begin
            cmd.count = 1'b1;
         end
         sdtf_pkg::ST_LAYOUT: begin
            cmd.layout = 1'b1;
         end
         sdtf_pkg::ST_EMIT: begin
            cmd.emit = sts.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/sdtf_dpath.sv =====
// datapath: shift-add-3 binary to bcd, field layout, character output register
// depends on sdtf_pkg
`default_nettype none

module sdtf_dpath (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire sdtf_pkg::ctrl_cmd_type         cmd,
   output sdtf_pkg::ctrl_sts_type              sts,
   input  wire signed [sdtf_pkg::VALUE_W-1:0]  req_value,
   input  wire                                 req_force_plus,
   input  wire                                 req_space_sign,
   input  wire                                 req_left_justify,
   input  wire                                 req_zero_pad,
   input  wire                                 req_has_precision,
   input  wire        [sdtf_pkg::PREC_W-1:0]   req_precision,
   input  wire        [sdtf_pkg::COUNT_W-1:0]  req_field_width,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic       [7:0]                    rsp_char_out,
   output logic                                rsp_last_char,
   output logic       [sdtf_pkg::COUNT_W-1:0]  rsp_total_chars
);

   localparam int CW = sdtf_pkg::COUNT_W;

   // conversion state
   logic [sdtf_pkg::VALUE_W-1:0]                        mag_ff, mag_in;
   logic [sdtf_pkg::NUM_DIGITS-1:0][sdtf_pkg::DIGIT_W-1:0] bcd_ff, bcd_in;
   logic [sdtf_pkg::STEP_W-1:0]                         step_ff, step_in;

   // captured flags
   logic neg_ff, fplus_ff, nplus_ff, leftj_ff, zpad_ff, isprec_ff, suppress_ff;
   logic [sdtf_pkg::PREC_W-1:0] prec_ff;
   logic [CW-1:0]               width_ff;

   // measured parts
   logic [sdtf_pkg::NDIG_W-1:0] ndig_ff, ndig_in;
   logic [sdtf_pkg::PREC_W-1:0] nzero_ff, nzero_in;
   logic                        has_sign_ff, has_sign_in;
   logic [7:0]                  sign_ff, sign_in;

   // layout boundaries
   logic [CW-1:0] b_lead_ff, b_sign_ff, b_zero_ff, b_dig_ff, total_ff;
   logic [CW-1:0] b_lead_in, b_sign_in, b_zero_in, b_dig_in, total_in;
   logic [CW-1:0] pos_ff, pos_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    char_ff, char_in;
   logic          last_ff, last_in;
   logic [CW-1:0] tot_ff, tot_in;

   logic [CW-1:0] body, pad, zeros_len, trail_len, dig_off, pos_next;
   logic [sdtf_pkg::DIGIT_W-1:0] dig_sel;
   logic [sdtf_pkg::NDIG_W-1:0]  hi_digit;

   always_comb begin
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      step_in = step_ff;
      if (cmd.load) begin
         mag_in  = req_value[sdtf_pkg::VALUE_W-1] ? (~req_value + 1'b1) : req_value;
         bcd_in  = '0;
         step_in = '0;
      end else if (cmd.shift) begin
         for (int i = 0; i < sdtf_pkg::NUM_DIGITS; i++) begin
            if (bcd_ff[i] >= sdtf_pkg::DIGIT_W'(5)) begin
               bcd_in[i] = bcd_ff[i] + sdtf_pkg::DIGIT_W'(3);
            end
         end
         {bcd_in, mag_in} = {bcd_in, mag_ff} << 1;
         step_in = step_ff + 1'b1;
      end
   end

   assign sts.conv_done = (step_ff == sdtf_pkg::STEP_W'(sdtf_pkg::CONV_STEPS - 1));

   always_comb begin
      hi_digit = sdtf_pkg::NDIG_W'(1);
      for (int i = 0; i < sdtf_pkg::NUM_DIGITS; i++) begin
         if (bcd_ff[i] != '0) hi_digit = sdtf_pkg::NDIG_W'(i + 1);
      end
      ndig_in = suppress_ff ? '0 : hi_digit;
      nzero_in = '0;
      if (isprec_ff && ({2'b00, ndig_in} < prec_ff)) begin
         nzero_in = prec_ff - {2'b00, ndig_in};
      end
      has_sign_in = 1'b1;
      sign_in     = sdtf_pkg::CHAR_MINUS;
      if (fplus_ff && !neg_ff) begin
         sign_in = sdtf_pkg::CHAR_PLUS;
      end else if (nplus_ff && !neg_ff) begin
         sign_in = sdtf_pkg::CHAR_SPACE;
      end else if (!neg_ff) begin
         has_sign_in = 1'b0;
      end
   end

   always_comb begin
      body = CW'(has_sign_ff) + CW'(nzero_ff) + CW'(ndig_ff);
      pad  = (body < width_ff) ? (width_ff - body) : '0;
      b_lead_in = '0;
      zeros_len = CW'(nzero_ff);
      trail_len = '0;
      if (leftj_ff) begin
         trail_len = pad;
      end else if (zpad_ff && !isprec_ff) begin
         zeros_len = pad;
      end else begin
         b_lead_in = pad;
      end
      b_sign_in = b_lead_in + CW'(has_sign_ff);
      b_zero_in = b_sign_in + zeros_len;
      b_dig_in  = b_zero_in + CW'(ndig_ff);
      total_in  = b_dig_in + trail_len;
   end

   assign sts.empty = (total_in == '0);

   assign pos_next     = pos_ff + 1'b1;
   assign sts.last_pos = (pos_next == total_ff);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      dig_off = b_dig_ff - pos_next;
      dig_sel = bcd_ff[dig_off[sdtf_pkg::NDIG_W-1:0]];
      if (pos_ff < b_lead_ff) begin
         char_in = sdtf_pkg::CHAR_SPACE;
      end else if (pos_ff < b_sign_ff) begin
         char_in = sign_ff;
      end else if (pos_ff < b_zero_ff) begin
         char_in = sdtf_pkg::CHAR_ZERO;
      end else if (pos_ff < b_dig_ff) begin
         char_in = sdtf_pkg::CHAR_ZERO | {4'b0000, dig_sel};
      end else begin
         char_in = sdtf_pkg::CHAR_SPACE;
      end
      last_in = sts.last_pos;
      tot_in  = sts.last_pos ? total_ff : '0;
   end

   always_comb begin
      pos_in = pos_ff;
      if (cmd.layout) begin
         pos_in = '0;
      end else if (cmd.emit) begin
         pos_in = pos_next;
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      step_ff <= step_in;
      pos_ff  <= pos_in;
      if (cmd.load) begin
         neg_ff      <= req_value[sdtf_pkg::VALUE_W-1];
         fplus_ff    <= req_force_plus;
         nplus_ff    <= req_space_sign;
         leftj_ff    <= req_left_justify;
         zpad_ff     <= req_zero_pad;
         isprec_ff   <= req_has_precision;
         prec_ff     <= req_precision;
         width_ff    <= (req_field_width > CW'(sdtf_pkg::MAX_CHARS)) ?
                        CW'(sdtf_pkg::MAX_CHARS) : req_field_width;
         suppress_ff <= req_has_precision && (req_precision == '0) && (req_value == '0);
      end
      if (cmd.count) begin
         ndig_ff     <= ndig_in;
         nzero_ff    <= nzero_in;
         has_sign_ff <= has_sign_in;
         sign_ff     <= sign_in;
      end
      if (cmd.layout) begin
         b_lead_ff <= b_lead_in;
         b_sign_ff <= b_sign_in;
         b_zero_ff <= b_zero_in;
         b_dig_ff  <= b_dig_in;
         total_ff  <= total_in;
      end
      if (cmd.emit) begin
         char_ff <= char_in;
         last_ff <= last_in;
         tot_ff  <= tot_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_char_out    = char_ff;
   assign rsp_last_char   = last_ff;
   assign rsp_total_chars = tot_ff;

`ifndef SYNTHESIS
   a_emit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("beat loaded over a pending beat");

   a_load_clears_step: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (step_ff == '0))
      else $error("conversion step count not cleared on load");

   a_last_total_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && last_ff) |->
         (tot_ff != '0) && (tot_ff <= CW'(sdtf_pkg::MAX_CHARS)))
      else $error("total_chars out of range on final beat");

   a_total_only_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !last_ff) |-> (tot_ff == '0))
      else $error("total_chars nonzero on an inner beat");

   a_emit_in_field: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (pos_ff < total_ff))
      else $error("beat beyond the end of the field");
`endif

endmodule

`default_nettype wire

// ===== design/signed_decimal_text_formatter.sv =====
// top level of the signed decimal text formatter (one %d conversion)
// depends on sdtf_pkg, sdtf_if, sdtf_ctrl, sdtf_dpath
//
// usage:
//   req_chan carries one value and its format flags per beat; rsp_chan returns
//   the formatted text as ascii characters, one per beat, in print order.
//   the final beat of an item has last_char set and total_chars holding the
//   item's character count; inner beats carry total_chars of zero.
//   an item that prints nothing (zero value, precision zero, no sign, width
//   zero) produces no beat at all.
// timing:
//   a value goes through shift-add-3 binary to bcd conversion, then its digits
//   are counted and the field is laid out; after that the first character is
//   loaded into the output register. characters then follow one per cycle
//   while the receiver keeps ready high.
//   one item is worked at a time; the next is accepted once the final
//   character sits in the output register.
// reset and stall:
//   synchronous active-high reset drops the response valid and returns to idle.
//   a stalled receiver holds the current beat and pauses the sequencer.
`default_nettype none

module signed_decimal_text_formatter (
   input wire         clock,
   input wire         reset,
   sdtf_req_if.sink   req_chan,
   sdtf_rsp_if.source rsp_chan
);

   sdtf_pkg::ctrl_cmd_type cmd;
   sdtf_pkg::ctrl_sts_type sts;
   logic                   req_ready;

   assign req_chan.ready = req_ready;

   sdtf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sdtf_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_value         (req_chan.value),
      .req_force_plus    (req_chan.force_plus),
      .req_space_sign    (req_chan.space_sign),
      .req_left_justify  (req_chan.left_justify),
      .req_zero_pad      (req_chan.zero_pad),
      .req_has_precision (req_chan.has_precision),
      .req_precision     (req_chan.precision),
      .req_field_width   (req_chan.field_width),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_char_out      (rsp_chan.char_out),
      .rsp_last_char     (rsp_chan.last_char),
      .rsp_total_chars   (rsp_chan.total_chars)
   );

endmodule

`default_nettype wire
